// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Same-cycle implication that also holds across reset
`define ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/rtc_cal_pkg.sv =====
// Shared types, constants and calendar helpers for the RTC calendar counter.
// No dependencies.
`timescale 1ns / 1ps

package rtc_cal_pkg;

  localparam logic [5:0]  SEC_LAST     = 6'd59;
  localparam logic [5:0]  MIN_LAST     = 6'd59;
  localparam logic [4:0]  HOUR_LAST    = 5'd23;
  localparam logic [2:0]  WEEKDAY_LAST = 3'd7;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;

  localparam logic [3:0]  MON_FEB = 4'd2;
  localparam logic [3:0]  MON_APR = 4'd4;
  localparam logic [3:0]  MON_JUN = 4'd6;
  localparam logic [3:0]  MON_SEP = 4'd9;
  localparam logic [3:0]  MON_NOV = 4'd11;

  localparam logic [15:0] YEAR_RESET = 16'd2000;

  // Multiplicative inverse of 25 mod 2^16; y*INV25 <= DIV25_MAX iff 25 divides y
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct packed {
    cal_t cal;
    logic rolled;
  } result_t;

  // Gregorian leap rule without a divider
  function automatic logic is_leap(input logic [15:0] y);
    logic [31:0] prod;
    logic        div25;
    logic        div4;
    logic        div16;
    prod  = 32'(y) * 32'(INV25);
    div25 = (prod[15:0] <= DIV25_MAX);
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    if (div4 && div25) begin
      is_leap = div16;
    end else begin
      is_leap = div4;
    end
  endfunction

  // Last day of month; out-of-range month codes count as 31-day months
  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    month_length = len;
  endfunction

endpackage

// ===== rtl/rtc_calendar_counter.sv =====
// Top level of the RTC calendar counter: state registers and a two-entry result buffer.
// Depends on rtc_cal_pkg and rtc_cal_next.
`timescale 1ns / 1ps
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | mode, load_second .. load_weekday
//  out     | out_valid/out_ready | cur_second .. cur_year, day_rolled
//
// One request per cycle while in_ready is high; its result is written into the buffer.
// The calendar registers update in the cycle a request is accepted.
// Results wait in a two-entry buffer, so in_ready depends only on buffer fill.
// A request is taken while one result waits; two waiting results stall the input.
// Reset sets 00:00:00, weekday 1, January 1, 2000, and empties the buffer.

module rtc_calendar_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [5:0]  load_second,
  input  logic [5:0]  load_minute,
  input  logic [4:0]  load_hour,
  input  logic [15:0] load_year,
  input  logic [3:0]  load_month,
  input  logic [4:0]  load_day,
  input  logic [2:0]  load_weekday,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  cur_second,
  output logic [5:0]  cur_minute,
  output logic [4:0]  cur_hour,
  output logic [2:0]  cur_weekday,
  output logic [4:0]  cur_day,
  output logic [3:0]  cur_month,
  output logic [15:0] cur_year,
  output logic        day_rolled
);

  rtc_cal_pkg::cal_t    cal;
  rtc_cal_pkg::cal_t    cal_next;
  rtc_cal_pkg::cal_t    load;
  logic                 rolled;
  rtc_cal_pkg::result_t buf_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 pop;
  rtc_cal_pkg::result_t head;

  assign load = '{year: load_year, month: load_month, day: load_day,
                  weekday: load_weekday, hour: load_hour, minute: load_minute,
                  second: load_second};

  rtc_cal_next u_next (
    .cur    (cal),
    .mode   (mode),
    .load   (load),
    .nxt    (cal_next),
    .rolled (rolled)
  );

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Calendar state
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '{year: rtc_cal_pkg::YEAR_RESET, month: 4'd1, day: 5'd1, weekday: 3'd1,
               hour: 5'd0, minute: 6'd0, second: 6'd0};
    end else if (push) begin
      cal <= cal_next;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= '{cal: cal_next, rolled: rolled};
    end
  end

  assign head        = buf_mem[rd_ptr];
  assign cur_second  = head.cal.second;
  assign cur_minute  = head.cal.minute;
  assign cur_hour    = head.cal.hour;
  assign cur_weekday = head.cal.weekday;
  assign cur_day     = head.cal.day;
  assign cur_month   = head.cal.month;
  assign cur_year    = head.cal.year;
  assign day_rolled  = head.rolled;

endmodule

// ===== rtl/rtc_cal_next.sv =====
// Next-state logic of the calendar: one-second advance or full load.
// Depends on rtc_cal_pkg.
`timescale 1ns / 1ps

module rtc_cal_next (
  input  rtc_cal_pkg::cal_t cur,
  input  logic              mode,
  input  rtc_cal_pkg::cal_t load,
  output rtc_cal_pkg::cal_t nxt,
  output logic              rolled
);

  logic              sec_wrap;
  logic              min_wrap;
  logic              hour_wrap;
  logic              day_wrap;
  logic [4:0]        last_day;
  rtc_cal_pkg::cal_t adv;

  // Carry chain of the tick
  assign sec_wrap  = (cur.second >= rtc_cal_pkg::SEC_LAST);
  assign min_wrap  = sec_wrap && (cur.minute >= rtc_cal_pkg::MIN_LAST);
  assign hour_wrap = min_wrap && (cur.hour >= rtc_cal_pkg::HOUR_LAST);
  assign last_day  = rtc_cal_pkg::month_length(cur.month, rtc_cal_pkg::is_leap(cur.year));
  assign day_wrap  = (cur.day >= last_day);

  always_comb begin
    adv = cur;
    if (!sec_wrap) begin
      adv.second = cur.second + 6'd1;
    end else begin
      adv.second = 6'd0;
      if (!min_wrap) begin
        adv.minute = cur.minute + 6'd1;
      end else begin
        adv.minute = 6'd0;
        if (!hour_wrap) begin
          adv.hour = cur.hour + 5'd1;
        end else begin
          adv.hour = 5'd0;
          // midnight: weekday and date
          adv.weekday = (cur.weekday >= rtc_cal_pkg::WEEKDAY_LAST) ? 3'd1
                                                                  : cur.weekday + 3'd1;
          if (day_wrap) begin
            adv.day = 5'd1;
            if (cur.month >= rtc_cal_pkg::MONTH_LAST) begin
              adv.month = 4'd1;
              adv.year  = cur.year + 16'd1;
            end else begin
              adv.month = cur.month + 4'd1;
            end
          end else begin
            adv.day = cur.day + 5'd1;
          end
        end
      end
    end
  end

  assign nxt    = mode ? load : adv;
  assign rolled = !mode && hour_wrap;

endmodule

// ===== rtl/rtc_cal_check.sv =====
// Port-level checks for the RTC calendar counter, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtc_cal_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  cur_second,
  input logic [5:0]  cur_minute,
  input logic [4:0]  cur_hour,
  input logic        day_rolled
);

  logic at_midnight;

  // Time of day reads 00:00:00
  assign at_midnight = (cur_second == 6'd0) && (cur_minute == 6'd0) && (cur_hour == 5'd0);

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Midnight rollover always shows 00:00:00
  `ASSERT_IMPL(a_roll_midnight, out_valid && day_rolled, at_midnight)

  // Nothing waiting means room for a request
  `ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)

  // Buffer is empty right after reset
  `ASSERT_ALWAYS(a_empty_after_rst, $past(rst), !out_valid)

endmodule

bind rtc_calendar_counter rtc_cal_check u_check (.*);

// ===== tb/sv/tb_rtc_calendar_counter.sv =====
// Self-checking testbench for rtc_calendar_counter: directed calendar corner cases, then
// random loads and tick runs; each result is checked against typed rows or a predictor.
// Depends on rtc_cal_pkg and the rtc_calendar_counter RTL.
`timescale 1ns / 1ps

module tb_rtc_calendar_counter;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam int unsigned MAX_GAP       = 15;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned STALL_LIMIT   = 600;
  localparam int unsigned DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_time_t;

  typedef struct packed {
    date_time_t cal;
    logic       rolled;
  } calendar_result_t;

  typedef struct packed {
    logic             op;
    date_time_t       load;
    logic             typed;
    calendar_result_t typed_result;
  } stimulus_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [5:0]  load_second;
  logic [5:0]  load_minute;
  logic [4:0]  load_hour;
  logic [15:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [2:0]  load_weekday;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  cur_second;
  logic [5:0]  cur_minute;
  logic [4:0]  cur_hour;
  logic [2:0]  cur_weekday;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [15:0] cur_year;
  logic        day_rolled;

  date_time_t       model_cal;
  calendar_result_t due_readings [$];
  stimulus_row_t    directed_rows [$];
  int unsigned      mismatches = 0;
  int unsigned      requests_sent = 0;
  bit               send_calm = 1'b0;
  bit               take_calm = 1'b0;

  rtc_calendar_counter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .load_second  (load_second),
    .load_minute  (load_minute),
    .load_hour    (load_hour),
    .load_year    (load_year),
    .load_month   (load_month),
    .load_day     (load_day),
    .load_weekday (load_weekday),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cur_second   (cur_second),
    .cur_minute   (cur_minute),
    .cur_hour     (cur_hour),
    .cur_weekday  (cur_weekday),
    .cur_day      (cur_day),
    .cur_month    (cur_month),
    .cur_year     (cur_year),
    .day_rolled   (day_rolled)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic date_time_t calendar_at(int unsigned y, int unsigned mo, int unsigned d,
                                             int unsigned wd, int unsigned h, int unsigned mi,
                                             int unsigned s);
    date_time_t c;
    c.year    = 16'(y);
    c.month   = 4'(mo);
    c.day     = 5'(d);
    c.weekday = 3'(wd);
    c.hour    = 5'(h);
    c.minute  = 6'(mi);
    c.second  = 6'(s);
    return c;
  endfunction

  // Gregorian rule: centuries only when divisible by 400
  function automatic bit leap_year(logic [15:0] y);
    if ((y % 16'd100) == 16'd0) return (y % 16'd400) == 16'd0;
    return (y % 16'd4) == 16'd0;
  endfunction

  // Out-of-range month codes count as 31-day months
  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [15:0] y);
    case (m)
      rtc_cal_pkg::MON_APR, rtc_cal_pkg::MON_JUN,
      rtc_cal_pkg::MON_SEP, rtc_cal_pkg::MON_NOV: return 5'd30;
      rtc_cal_pkg::MON_FEB: return leap_year(y) ? 5'd29 : 5'd28;
      default: return 5'd31;
    endcase
  endfunction

  // Calendar predictor: applies one request to model_cal and returns the reading
  function automatic calendar_result_t advance_calendar(logic op, date_time_t load);
    calendar_result_t r;
    r.rolled = 1'b0;
    if (op == MODE_LOAD) begin
      model_cal = load;
    end else if (model_cal.second < rtc_cal_pkg::SEC_LAST) begin
      model_cal.second = model_cal.second + 6'd1;
    end else begin
      model_cal.second = 6'd0;
      if (model_cal.minute < rtc_cal_pkg::MIN_LAST) begin
        model_cal.minute = model_cal.minute + 6'd1;
      end else begin
        model_cal.minute = 6'd0;
        if (model_cal.hour < rtc_cal_pkg::HOUR_LAST) begin
          model_cal.hour = model_cal.hour + 5'd1;
        end else begin
          // midnight: weekday and date advance
          model_cal.hour = 5'd0;
          r.rolled = 1'b1;
          if (model_cal.weekday >= rtc_cal_pkg::WEEKDAY_LAST) model_cal.weekday = 3'd1;
          else model_cal.weekday = model_cal.weekday + 3'd1;
          if (model_cal.day >= days_in_month(model_cal.month, model_cal.year)) begin
            model_cal.day = 5'd1;
            if (model_cal.month >= rtc_cal_pkg::MONTH_LAST) begin
              model_cal.month = 4'd1;
              model_cal.year  = model_cal.year + 16'd1;
            end else begin
              model_cal.month = model_cal.month + 4'd1;
            end
          end else begin
            model_cal.day = model_cal.day + 5'd1;
          end
        end
      end
    end
    r.cal = model_cal;
    return r;
  endfunction

  // Shaped loads land close to midnight and month end; the rest is raw bits
  function automatic date_time_t random_load(bit shaped);
    date_time_t  c;
    logic [4:0]  len;
    if (!shaped) begin
      c.year    = 16'($urandom);
      c.month   = 4'($urandom);
      c.day     = 5'($urandom);
      c.weekday = 3'($urandom);
      c.hour    = 5'($urandom);
      c.minute  = 6'($urandom);
      c.second  = 6'($urandom);
      return c;
    end
    case ($urandom_range(0, 4))
      0: c.year = 16'($urandom_range(0, 65535));
      1: c.year = 16'(100 * $urandom_range(0, 655));
      2: c.year = 16'(400 * $urandom_range(0, 163));
      3: c.year = 16'(4 * $urandom_range(0, 16383));
      default: c.year = 16'hFFFF;
    endcase
    c.month = 4'($urandom_range(1, 12));
    len = days_in_month(c.month, c.year);
    if ($urandom_range(0, 2) != 0) c.day = len - 5'($urandom_range(0, 1));
    else c.day = 5'($urandom_range(1, len));
    c.weekday = 3'($urandom_range(1, 7));
    c.hour    = ($urandom_range(0, 3) != 0) ? rtc_cal_pkg::HOUR_LAST
                                             : 5'($urandom_range(0, 23));
    c.minute  = ($urandom_range(0, 3) != 0) ? rtc_cal_pkg::MIN_LAST
                                             : 6'($urandom_range(0, 59));
    c.second  = 6'($urandom_range(45, 59));
    return c;
  endfunction

  task automatic add_row(logic op, date_time_t load, logic typed, date_time_t exp_cal,
                         logic exp_rolled);
    stimulus_row_t row;
    row.op                  = op;
    row.load                = load;
    row.typed               = typed;
    row.typed_result.cal    = exp_cal;
    row.typed_result.rolled = exp_rolled;
    directed_rows.push_back(row);
  endtask

  // Drive one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_request(logic op, date_time_t load, logic typed,
                              calendar_result_t typed_result);
    int unsigned      gap;
    calendar_result_t prediction;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    mode         = op;
    load_second  = load.second;
    load_minute  = load.minute;
    load_hour    = load.hour;
    load_year    = load.year;
    load_month   = load.month;
    load_day     = load.day;
    load_weekday = load.weekday;
    do @(posedge clk); while (!in_ready);
    prediction = advance_calendar(op, load);
    due_readings.push_back(typed ? typed_result : prediction);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic compare_field(string label, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Result side: random back-pressure, each reading checked against the oldest expectation
  initial begin : reading_checker
    int unsigned      gap;
    calendar_result_t want;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (due_readings.size() == 0) begin
        $display("%0t: reading with no request pending, second %0d day %0d", $time,
                 cur_second, cur_day);
        mismatches++;
      end else begin
        want = due_readings.pop_front();
        compare_field("cur_second",  16'(want.cal.second),  16'(cur_second));
        compare_field("cur_minute",  16'(want.cal.minute),  16'(cur_minute));
        compare_field("cur_hour",    16'(want.cal.hour),    16'(cur_hour));
        compare_field("cur_weekday", 16'(want.cal.weekday), 16'(cur_weekday));
        compare_field("cur_day",     16'(want.cal.day),     16'(cur_day));
        compare_field("cur_month",   16'(want.cal.month),   16'(cur_month));
        compare_field("cur_year",    want.cal.year,         cur_year);
        compare_field("day_rolled",  16'(want.rolled),      16'(day_rolled));
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin : stall_watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst === 1'b0);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin : request_source
    date_time_t       cal;
    calendar_result_t no_result;
    int unsigned      tick_run;

    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_TICK;
    load_second  = '0;
    load_minute  = '0;
    load_hour    = '0;
    load_year    = '0;
    load_month   = '0;
    load_day     = '0;
    load_weekday = '0;
    no_result    = '0;
    model_cal    = calendar_at(rtc_cal_pkg::YEAR_RESET, 1, 1, 1, 0, 0, 0);

    // directed table; typed rows carry an expectation that can be read off directly
    add_row(MODE_TICK, '0, 1'b1, calendar_at(2000, 1, 1, 1, 0, 0, 1), 1'b0);
    cal = calendar_at(65535, 12, 31, 7, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    // weekday 7, December and year all wrap at once
    add_row(MODE_TICK, '0, 1'b1, calendar_at(0, 1, 1, 1, 0, 0, 0), 1'b1);
    cal = calendar_at(2000, 2, 28, 3, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '1, 1'b0, '0, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    cal = calendar_at(1900, 2, 28, 5, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    cal = calendar_at(2024, 2, 29, 4, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '1, 1'b0, '0, 1'b0);
    cal = calendar_at(2023, 4, 30, 6, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    cal = calendar_at(2023, 11, 29, 2, 23, 59, 58);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    // month, hour, minute, second out of range at all-ones codes, day 31, year and weekday zero
    cal = calendar_at(0, 15, 31, 0, 31, 63, 63);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b1, calendar_at(1, 1, 1, 1, 0, 0, 0), 1'b1);
    // day zero, month zero, weekday zero
    cal = calendar_at(2023, 0, 0, 0, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    cal = calendar_at(2100, 13, 30, 6, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    cal = calendar_at(2100, 2, 28, 1, 23, 59, 59);
    add_row(MODE_LOAD, cal, 1'b1, cal, 1'b0);
    add_row(MODE_TICK, '0, 1'b0, '0, 1'b0);
    add_row(MODE_LOAD, '0, 1'b1, '0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].load, directed_rows[i].typed,
                   directed_rows[i].typed_result);

    // random part: mostly a shaped load followed by a run of ticks
    while (requests_sent < RANDOM_ITEMS + directed_rows.size()) begin
      send_request(MODE_LOAD, random_load($urandom_range(0, 9) != 0), 1'b0, no_result);
      tick_run = $urandom_range(0, 24);
      repeat (tick_run) send_request(MODE_TICK, random_load(1'b0), 1'b0, no_result);
    end
    in_valid = 1'b0;

    while (due_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rtc_cal_pkg.sv
rtl/rtc_cal_next.sv
rtl/rtc_calendar_counter.sv
rtl/rtc_cal_check.sv
tb/sv/tb_rtc_calendar_counter.sv
